// ===== design/acsd_pkg.sv =====
// Shared types and constants for the accelerometer step detector.
// No dependencies; every design file but acsd_checker refers to it by scoped names.
package acsd_pkg;

  localparam int WINDOW_LEN_DEF = 10;

  localparam int MAG_W = 32;
  localparam int TIME_W = 32;
  localparam int DEB_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_PEAK_LEVEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VALLEY_LEVEL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd2;

  localparam logic [MAG_W-1:0] PEAK_LEVEL_RST = 32'd386547057;
  localparam logic [MAG_W-1:0] VALLEY_LEVEL_RST = 32'd171798692;
  localparam logic [DEB_W-1:0] DEBOUNCE_RST = 16'd250;

  typedef struct packed {
    logic [MAG_W-1:0] peak_level_sq;
    logic [MAG_W-1:0] valley_level_sq;
    logic [DEB_W-1:0] debounce_ms;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic [TIME_W-1:0] now;
  } tag_t;

endpackage

// ===== design/accel_step_detector_top.sv =====
// Accelerometer step detector, top level: ports, configuration registers,
// input register and pipeline control. Depends on acsd_pkg and its stages.
// An item passes the input, squaring, window and result registers in that order.
// Throughput: one item per cycle, set by the window compare and
// debounce loop of the decision stage; a stalled result holds the whole line.
// Reset (synchronous): window, step time and count cleared, registers at defaults.
module accel_step_detector_top #(
  parameter int WINDOW_LEN = acsd_pkg::WINDOW_LEN_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic [31:0] now_ms,
  output logic out_valid,
  input  logic out_stall,
  output logic step_seen,
  output logic peak_found,
  output logic valley_found,
  output logic [31:0] steps_total,
  input  logic cfg_we,
  input  logic [acsd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [acsd_pkg::CFG_DATA_W-1:0] cfg_data
);

  acsd_pkg::cfg_t cfg;
  acsd_pkg::tag_t tag1;
  acsd_pkg::tag_t tag2;
  acsd_pkg::tag_t tag3;
  logic signed [15:0] ax;
  logic signed [15:0] ay;
  logic signed [15:0] az;
  logic [acsd_pkg::MAG_W-1:0] sq_x;
  logic [acsd_pkg::MAG_W-1:0] sq_y;
  logic [acsd_pkg::MAG_W-1:0] sq_z;
  logic [acsd_pkg::MAG_W-1:0] win [WINDOW_LEN];
  logic advance;

  assign advance = !(out_valid && out_stall);
  assign in_stall = !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.peak_level_sq <= acsd_pkg::PEAK_LEVEL_RST;
      cfg.valley_level_sq <= acsd_pkg::VALLEY_LEVEL_RST;
      cfg.debounce_ms <= acsd_pkg::DEBOUNCE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        acsd_pkg::REG_PEAK_LEVEL: cfg.peak_level_sq <= cfg_data;
        acsd_pkg::REG_VALLEY_LEVEL: cfg.valley_level_sq <= cfg_data;
        acsd_pkg::REG_DEBOUNCE: cfg.debounce_ms <= cfg_data[acsd_pkg::DEB_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1.valid <= 1'b0;
    end else if (advance) begin
      tag1.valid <= in_valid;
    end
    if (advance) begin
      tag1.now <= now_ms;
      ax <= accel_x;
      ay <= accel_y;
      az <= accel_z;
    end
  end

  acsd_square u_square (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .tag_in  (tag1),
    .ax      (ax),
    .ay      (ay),
    .az      (az),
    .tag_out (tag2),
    .sq_x    (sq_x),
    .sq_y    (sq_y),
    .sq_z    (sq_z)
  );

  acsd_window #(.WINDOW_LEN(WINDOW_LEN)) u_window (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .tag_in  (tag2),
    .sq_x    (sq_x),
    .sq_y    (sq_y),
    .sq_z    (sq_z),
    .tag_out (tag3),
    .win     (win)
  );

  acsd_decide #(.WINDOW_LEN(WINDOW_LEN)) u_decide (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .cfg          (cfg),
    .tag_in       (tag3),
    .win          (win),
    .out_valid    (out_valid),
    .step_seen    (step_seen),
    .peak_found   (peak_found),
    .valley_found (valley_found),
    .steps_total  (steps_total)
  );

endmodule

// ===== design/acsd_square.sv =====
// Squaring stage: registers the square of each acceleration axis.
// Depends on acsd_pkg.
module acsd_square (
  input  logic clk,
  input  logic rst,
  input  logic advance,
  input  acsd_pkg::tag_t tag_in,
  input  logic signed [15:0] ax,
  input  logic signed [15:0] ay,
  input  logic signed [15:0] az,
  output acsd_pkg::tag_t tag_out,
  output logic [acsd_pkg::MAG_W-1:0] sq_x,
  output logic [acsd_pkg::MAG_W-1:0] sq_y,
  output logic [acsd_pkg::MAG_W-1:0] sq_z
);

  logic signed [acsd_pkg::MAG_W-1:0] px;
  logic signed [acsd_pkg::MAG_W-1:0] py;
  logic signed [acsd_pkg::MAG_W-1:0] pz;

  assign px = ax * ax;
  assign py = ay * ay;
  assign pz = az * az;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out.valid <= 1'b0;
    end else if (advance) begin
      tag_out.valid <= tag_in.valid;
    end
    if (advance) begin
      tag_out.now <= tag_in.now;
      sq_x <= unsigned'(px);
      sq_y <= unsigned'(py);
      sq_z <= unsigned'(pz);
    end
  end

endmodule

// ===== design/acsd_window.sv =====
// Magnitude window: sums the squares and shifts the result into a line
// kept in arrival order, oldest at index 0. Depends on acsd_pkg.
module acsd_window #(
  parameter int WINDOW_LEN = acsd_pkg::WINDOW_LEN_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic advance,
  input  acsd_pkg::tag_t tag_in,
  input  logic [acsd_pkg::MAG_W-1:0] sq_x,
  input  logic [acsd_pkg::MAG_W-1:0] sq_y,
  input  logic [acsd_pkg::MAG_W-1:0] sq_z,
  output acsd_pkg::tag_t tag_out,
  output logic [acsd_pkg::MAG_W-1:0] win [WINDOW_LEN]
);

  logic [acsd_pkg::MAG_W-1:0] mag;

  assign mag = sq_x + sq_y + sq_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out.valid <= 1'b0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win[i] <= '0;
      end
    end else if (advance) begin
      tag_out.valid <= tag_in.valid;
      if (tag_in.valid) begin
        for (int i = 0; i < WINDOW_LEN - 1; i++) begin
          win[i] <= win[i+1];
        end
        win[WINDOW_LEN-1] <= mag;
      end
    end
    if (advance) begin
      tag_out.now <= tag_in.now;
    end
  end

endmodule

// ===== design/acsd_decide.sv =====
// Decision stage: peak and valley tests on the window middle, debounce,
// step count and the result register. Depends on acsd_pkg.
module acsd_decide #(
  parameter int WINDOW_LEN = acsd_pkg::WINDOW_LEN_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic advance,
  input  acsd_pkg::cfg_t cfg,
  input  acsd_pkg::tag_t tag_in,
  input  logic [acsd_pkg::MAG_W-1:0] win [WINDOW_LEN],
  output logic out_valid,
  output logic step_seen,
  output logic peak_found,
  output logic valley_found,
  output logic [31:0] steps_total
);

  localparam int MID = WINDOW_LEN / 2;

  logic [acsd_pkg::TIME_W-1:0] last_step_time;
  logic [31:0] step_counter;
  logic [31:0] step_counter_next;
  logic [acsd_pkg::TIME_W-1:0] elapsed;
  logic [acsd_pkg::MAG_W-1:0] mid;
  logic peak;
  logic valley;
  logic step;

  assign mid = win[MID];
  assign elapsed = tag_in.now - last_step_time;

  always_comb begin
    peak = mid > cfg.peak_level_sq;
    valley = mid < cfg.valley_level_sq;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      if (i != MID) begin
        if (mid < win[i]) begin
          peak = 1'b0;
        end
        if (mid > win[i]) begin
          valley = 1'b0;
        end
      end
    end
    step = (peak || valley) &&
           (elapsed > {{(acsd_pkg::TIME_W - acsd_pkg::DEB_W){1'b0}}, cfg.debounce_ms});
    step_counter_next = step ? step_counter + 32'd1 : step_counter;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      last_step_time <= '0;
      step_counter <= '0;
    end else if (advance) begin
      out_valid <= tag_in.valid;
      if (tag_in.valid) begin
        step_counter <= step_counter_next;
        if (step) begin
          last_step_time <= tag_in.now;
        end
      end
    end
    if (advance && tag_in.valid) begin
      step_seen <= step;
      peak_found <= peak;
      valley_found <= valley;
      steps_total <= step_counter_next;
    end
  end

endmodule

// ===== design/acsd_checker.sv =====
// Port-level checks for the step detector, attached to the top level by bind.
// Depends on accel_step_detector_top.
module acsd_checker (
  input logic clk,
  input logic rst,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic step_seen,
  input logic peak_found,
  input logic valley_found,
  input logic [31:0] steps_total
);

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  a_stall_links: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output back-pressure");

  a_step_flag: assert property (@(posedge clk) disable iff (rst)
    (out_valid && step_seen) |-> (peak_found || valley_found))
    else $error("step without peak or valley");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(steps_total) && $stable(step_seen)))
    else $error("stalled result changed");

endmodule

bind accel_step_detector_top acsd_checker u_acsd_checker (.*);

// ===== bench/tb_accel_step_detector_top.sv =====
// Testbench for accel_step_detector_top: directed and random accelerometer items,
// per-item step/peak/valley prediction, field-by-field checks of every result.
// Depends on acsd_pkg and the step detector RTL.
module tb_accel_step_detector_top;

  localparam int WIN = acsd_pkg::WINDOW_LEN_DEF;
  localparam int LATENCY = 3;
  localparam int LIMIT = 200000;
  localparam logic [acsd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [acsd_pkg::MAG_W-1:0] MAG_MAX = 32'd3221225472;

  typedef struct packed {
    logic step;
    logic peak;
    logic valley;
    logic [31:0] total;
  } step_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] accel_x = '0;
  logic signed [15:0] accel_y = '0;
  logic signed [15:0] accel_z = '0;
  logic [31:0] now_ms = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic step_seen;
  logic peak_found;
  logic valley_found;
  logic [31:0] steps_total;
  logic cfg_we = 1'b0;
  logic [acsd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [acsd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  accel_step_detector_top dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .accel_x(accel_x),
    .accel_y(accel_y),
    .accel_z(accel_z),
    .now_ms(now_ms),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .step_seen(step_seen),
    .peak_found(peak_found),
    .valley_found(valley_found),
    .steps_total(steps_total),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // detector state as the block should hold it
  logic [acsd_pkg::MAG_W-1:0] window_mag [WIN] = '{default: '0};
  int next_slot = 0;
  logic [acsd_pkg::TIME_W-1:0] last_step_ms = '0;
  logic [31:0] step_count = '0;
  logic [acsd_pkg::MAG_W-1:0] peak_level = acsd_pkg::PEAK_LEVEL_RST;
  logic [acsd_pkg::MAG_W-1:0] valley_level = acsd_pkg::VALLEY_LEVEL_RST;
  logic [acsd_pkg::DEB_W-1:0] debounce = acsd_pkg::DEBOUNCE_RST;

  step_result_t step_results_due [$];
  step_result_t due;

  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;
  int hold_cycles = 0;
  int cycles = 0;
  int mismatches = 0;
  int items_sent = 0;
  int results_checked = 0;
  int steps_seen = 0;
  int peaks_seen = 0;
  int valleys_seen = 0;
  logic [31:0] now_clk = '0;

  function automatic logic [31:0] axis_square(logic [15:0] v);
    int s;
    int unsigned a;
    s = int'($signed(v));
    a = (s < 0) ? -s : s;
    return a * a;
  endfunction

  function automatic step_result_t detect_step(logic [15:0] ax, logic [15:0] ay,
                                               logic [15:0] az, logic [31:0] t);
    logic [31:0] mag;
    logic [31:0] mid;
    logic [31:0] gap;
    int mid_slot;
    step_result_t r;
    mag = axis_square(ax) + axis_square(ay) + axis_square(az);
    window_mag[next_slot] = mag;
    next_slot = (next_slot + 1) % WIN;
    mid_slot = (next_slot + WIN / 2) % WIN;
    mid = window_mag[mid_slot];
    r.peak = mid > peak_level;
    r.valley = mid < valley_level;
    for (int i = 0; i < WIN; i++) begin
      if (i != mid_slot) begin
        if (mid < window_mag[i]) r.peak = 1'b0;
        if (mid > window_mag[i]) r.valley = 1'b0;
      end
    end
    gap = t - last_step_ms;
    r.step = (r.peak || r.valley) && (gap > {16'd0, debounce});
    if (r.step) begin
      last_step_ms = t;
      step_count = step_count + 32'd1;
    end
    r.total = step_count;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches < 50)
      $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want,
               results_checked);
    mismatches++;
  endtask

  task automatic send_item(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                           logic [31:0] t);
    @(negedge clk);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    accel_x <= ax;
    accel_y <= ay;
    accel_z <= az;
    now_ms <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    step_results_due.push_back(detect_step(ax, ay, az, t));
    items_sent++;
  endtask

  task automatic drain_results;
    @(negedge clk);
    in_valid <= 1'b0;
    while (step_results_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(logic [acsd_pkg::CFG_IDX_W-1:0] idx,
                           logic [acsd_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      acsd_pkg::REG_PEAK_LEVEL: peak_level = data;
      acsd_pkg::REG_VALLEY_LEVEL: valley_level = data;
      acsd_pkg::REG_DEBOUNCE: debounce = data[acsd_pkg::DEB_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // receiver: long hold-off when asked, else random stall
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (step_results_due.size() == 0) begin
        report_mismatch("result with nothing pending", steps_total, 32'd0);
      end else begin
        due = step_results_due.pop_front();
        if (step_seen !== due.step)
          report_mismatch("step_seen", 32'(step_seen), 32'(due.step));
        if (peak_found !== due.peak)
          report_mismatch("peak_found", 32'(peak_found), 32'(due.peak));
        if (valley_found !== due.valley)
          report_mismatch("valley_found", 32'(valley_found), 32'(due.valley));
        if (steps_total !== due.total) report_mismatch("steps_total", steps_total, due.total);
        results_checked++;
        steps_seen += int'(due.step);
        peaks_seen += int'(due.peak);
        valleys_seen += int'(due.valley);
      end
    end
  end

  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles == LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic test_window_after_reset;
    snd_idle_pct = 0;
    rcv_stall_pct = 0;
    send_item(16'd0, 16'd0, 16'd0, 32'd0);
    send_item(16'd0, 16'd0, 16'd0, 32'd250);
    send_item(16'd0, 16'd0, 16'd0, 32'd251);
    send_item(16'h8000, 16'h8000, 16'h8000, 32'd600);
    send_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 32'd601);
    send_item(16'h8000, 16'd0, 16'd0, 32'd900);
    send_item(16'd0, 16'h7FFF, 16'd0, 32'd1200);
    send_item(16'd0, 16'd0, 16'h8000, 32'd1500);
    send_item(16'd16384, 16'd0, 16'd0, 32'd1800);
    send_item(16'd0, -16'sd16384, 16'd0, 32'd2100);
    send_item(16'd1, 16'hFFFF, 16'd1, 32'hFFFF_FFFF);
    send_item(16'd0, 16'd0, 16'd0, 32'h0000_00FF);
  endtask

  task automatic test_register_writes;
    drain_results;
    write_reg(acsd_pkg::REG_PEAK_LEVEL, 32'd0);
    write_reg(acsd_pkg::REG_VALLEY_LEVEL, MAG_MAX);
    write_reg(acsd_pkg::REG_DEBOUNCE, 32'd0);
    // once the window is flat: peak and valley together, one step each item
    for (int i = 0; i < 11; i++)
      send_item(16'd16384, 16'd0, 16'd0, 32'd5000 + i);
    drain_results;
    write_reg(acsd_pkg::REG_DEBOUNCE, 32'hABCD_0005);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    write_reg(acsd_pkg::REG_PEAK_LEVEL, MAG_MAX);
    write_reg(acsd_pkg::REG_VALLEY_LEVEL, 32'd0);
    for (int i = 0; i < 3; i++)
      send_item(16'h8000, 16'h8000, 16'h8000, 32'd6000 + 10 * i);
  endtask

  task automatic test_random_traffic(int count, int snd_pct, int rcv_pct);
    int mode;
    int period;
    int amp;
    int ph;
    int tri_pos;
    int zv;
    int jx;
    int jy;
    int dt_max;
    logic [15:0] ax;
    logic [15:0] ay;
    logic [15:0] az;
    snd_idle_pct = snd_pct;
    rcv_stall_pct = rcv_pct;
    mode = 0;
    period = 8;
    amp = 8000;
    ph = 0;
    dt_max = 60;
    ax = '0;
    ay = '0;
    az = '0;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        mode = ($urandom_range(9) < 7) ? 0 : $urandom_range(2, 1);
        period = $urandom_range(16, 6);
        amp = $urandom_range(16000, 2000);
        dt_max = $urandom_range(120, 10);
        ph = 0;
        ax = 16'($urandom);
        ay = 16'($urandom);
        az = 16'($urandom);
      end
      case (mode)
        0: begin
          tri_pos = (ph < period / 2) ? ph : period - ph;
          zv = 16384 - amp / 2 + (amp * tri_pos * 2) / period;
          jx = $urandom_range(1000);
          jy = $urandom_range(1000);
          ax = 16'(jx - 500);
          ay = 16'(jy - 500);
          az = 16'(zv);
          ph = (ph + 1) % period;
          now_clk = now_clk + $urandom_range(dt_max, 1);
        end
        1: begin
          ax = 16'($urandom);
          ay = 16'($urandom);
          az = 16'($urandom);
          if ($urandom_range(3) == 0) now_clk = $urandom;
          else now_clk = now_clk + $urandom_range(400);
        end
        default: now_clk = now_clk + $urandom_range(dt_max);
      endcase
      send_item(ax, ay, az, now_clk);
    end
  endtask

  task automatic test_backpressure;
    drain_results;
    snd_idle_pct = 0;
    rcv_stall_pct = 0;
    hold_cycles = 80;
    for (int i = 0; i < 40; i++) begin
      now_clk = now_clk + $urandom_range(200, 20);
      send_item(16'($urandom), 16'($urandom), 16'($urandom), now_clk);
    end
    drain_results;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_window_after_reset;
    test_register_writes;

    drain_results;
    write_reg(acsd_pkg::REG_PEAK_LEVEL, acsd_pkg::PEAK_LEVEL_RST);
    write_reg(acsd_pkg::REG_VALLEY_LEVEL, acsd_pkg::VALLEY_LEVEL_RST);
    write_reg(acsd_pkg::REG_DEBOUNCE, 32'(acsd_pkg::DEBOUNCE_RST));
    test_random_traffic(280, 0, 0);

    drain_results;
    write_reg(acsd_pkg::REG_PEAK_LEVEL, $urandom_range(MAG_MAX / 2));
    write_reg(acsd_pkg::REG_VALLEY_LEVEL, $urandom_range(MAG_MAX));
    write_reg(acsd_pkg::REG_DEBOUNCE, 32'd0);
    test_random_traffic(280, 74, 0);

    drain_results;
    write_reg(acsd_pkg::REG_PEAK_LEVEL, acsd_pkg::PEAK_LEVEL_RST);
    write_reg(acsd_pkg::REG_VALLEY_LEVEL, acsd_pkg::VALLEY_LEVEL_RST);
    write_reg(acsd_pkg::REG_DEBOUNCE, 32'hFFFF_FFFF);
    test_random_traffic(280, 0, 74);

    drain_results;
    write_reg(acsd_pkg::REG_PEAK_LEVEL, $urandom_range(MAG_MAX));
    write_reg(acsd_pkg::REG_VALLEY_LEVEL, $urandom_range(MAG_MAX));
    write_reg(acsd_pkg::REG_DEBOUNCE, $urandom_range(400));
    now_clk = 32'hFFFF_F000;
    test_random_traffic(280, 18, 18);

    test_backpressure;

    drain_results;
    if (step_results_due.size() != 0)
      report_mismatch("results never returned", 32'd0, step_results_due.size());
    $display("sent %0d items, checked %0d results over %0d cycles", items_sent,
             results_checked, cycles);
    $display("steps %0d, peaks %0d, valleys %0d, mismatches %0d", steps_seen,
             peaks_seen, valleys_seen, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
